// ----- hdl/crls_pkg.sv -----
// Shared types and constants for the cable robot length stepper.
// Used by the controller, the datapath, the root unit and the top level.
`default_nettype none

package crls_pkg;

   localparam int NumCables   = 4;
   localparam int CoordW      = 8;
   localparam int LenW        = 10;
   localparam int DirW        = 2;
   localparam int RootW       = 9;
   localparam int RadW        = 2 * RootW;
   localparam int SqW         = 2 * CoordW;
   localparam int IdxW        = 2;
   localparam int ReqDataW    = 16;
   localparam int RspDataW    = 16;
   localparam int DefCoordW   = 8;

   localparam logic [LenW-1:0]   ResetLength = 10'd30;
   localparam logic [CoordW-1:0] ResetBoard  = 8'd20;

   localparam logic ModeLoad = 1'b0;
   localparam logic ModeTick = 1'b1;

   localparam logic [DirW-1:0] DirNone = 2'b00;
   localparam logic [DirW-1:0] DirPull = 2'b01;
   localparam logic [DirW-1:0] DirPay  = 2'b11;

   typedef struct packed {
      logic capture;
      logic set_accept;
      logic tick;
      logic abs_en;
      logic mul_en;
      logic root_start;
      logic store;
      logic emit;
   } crls_cmd_type;

   typedef struct packed {
      logic mode_tick;
      logic any_travel;
      logic root_done;
      logic last_cable;
      logic rsp_free;
   } crls_status_type;

endpackage

`default_nettype wire

// ----- hdl/crls_isqrt.sv -----
// Iterative floor square root, one result bit per cycle.
// Depends on crls_pkg for widths.
`default_nettype none

module crls_isqrt
   import crls_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [RadW-1:0]  radicand,
   output logic                  done,
   output logic [RootW-1:0]      root
);

   localparam int RemW = RootW + 1;
   localparam int TrW  = RootW + 3;
   localparam int CntW = $clog2(RootW);

   logic [RadW-1:0]  rad_ff;
   logic [RemW-1:0]  rem_ff;
   logic [RootW-1:0] root_ff;
   logic [CntW-1:0]  cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [TrW-1:0]   rem_sh;
   logic [TrW-1:0]   trial;
   logic [TrW-1:0]   diff;
   logic             fits;
   logic [RemW-1:0]  rem_in;
   logic [RootW-1:0] root_in;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[RadW-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      diff    = rem_sh - trial;
      fits    = (rem_sh >= trial);
      rem_in  = fits ? diff[RemW-1:0] : rem_sh[RemW-1:0];
      root_in = {root_ff[RootW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == '0)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= CntW'(RootW - 1);
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RadW-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
         cnt_ff  <= cnt_ff - 1'b1;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

// ----- hdl/crls_dp.sv -----
// Datapath: cable state, anchor distances, squares, root unit and result register.
// Depends on crls_pkg and crls_isqrt.
`default_nettype none

module crls_dp
   import crls_pkg::*;
#(
   parameter int COORD_WIDTH = DefCoordW
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire crls_cmd_type          cmd,
   output crls_status_type            status,
   input  wire logic [ReqDataW-1:0]   req_tdata,
   input  wire logic                  req_tuser,
   input  wire logic                  csr_valid,
   input  wire logic [CoordW-1:0]     csr_data,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic [RspDataW-1:0]        rsp_tdata
);

   localparam logic [CoordW-1:0] CoordMask =
      (COORD_WIDTH >= CoordW) ? {CoordW{1'b1}} : CoordW'((1 << COORD_WIDTH) - 1);

   logic [CoordW-1:0] board_ff;
   logic [CoordW-1:0] x_ff, y_ff;
   logic              mode_ff;
   logic              accepted_ff;
   logic [IdxW-1:0]   idx_ff;
   logic [CoordW-1:0] absx_ff, absy_ff;
   logic [SqW-1:0]    sqx_ff, sqy_ff;
   logic [DirW-1:0]   dir_ff    [NumCables];
   logic [LenW-1:0]   len_ff    [NumCables];
   logic [LenW-1:0]   travel_ff [NumCables];
   logic              rsp_valid_ff;
   logic [RspDataW-1:0] rsp_data_ff;

   logic [CoordW-1:0] anchor_x, anchor_y;
   logic [RadW-1:0]   radicand;
   logic              root_done;
   logic [RootW-1:0]  root;
   logic              any_travel;
   logic [DirW-1:0]   dir_in [NumCables];

   crls_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   always_comb begin
      // anchors: cable 0 (0,0), 1 (0,B), 2 (B,B), 3 (B,0)
      anchor_x = idx_ff[1] ? board_ff : '0;
      anchor_y = (idx_ff[1] ^ idx_ff[0]) ? board_ff : '0;
      radicand = RadW'(sqx_ff) + RadW'(sqy_ff);
      any_travel = 1'b0;
      for (int i = 0; i < NumCables; i++) begin
         any_travel = any_travel | (travel_ff[i] != '0);
         if (travel_ff[i][LenW-1]) begin
            dir_in[i] = DirPay;
         end else if (travel_ff[i] != '0) begin
            dir_in[i] = DirPull;
         end else begin
            dir_in[i] = DirNone;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         board_ff <= ResetBoard;
      end else if (csr_valid) begin
         board_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff        <= req_tdata[CoordW-1:0] & CoordMask;
         y_ff        <= req_tdata[2*CoordW-1:CoordW] & CoordMask;
         mode_ff     <= req_tuser;
         accepted_ff <= 1'b0;
         idx_ff      <= '0;
      end else begin
         if (cmd.set_accept) begin
            accepted_ff <= 1'b1;
         end
         if (cmd.store) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
      if (cmd.abs_en) begin
         absx_ff <= (x_ff >= anchor_x) ? x_ff - anchor_x : anchor_x - x_ff;
         absy_ff <= (y_ff >= anchor_y) ? y_ff - anchor_y : anchor_y - y_ff;
      end
      if (cmd.mul_en) begin
         sqx_ff <= absx_ff * absx_ff;
         sqy_ff <= absy_ff * absy_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NumCables; i++) begin
         if (cmd.capture) begin
            dir_ff[i] <= DirNone;
         end else if (cmd.tick) begin
            dir_ff[i] <= dir_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumCables; i++) begin
            len_ff[i]    <= ResetLength;
            travel_ff[i] <= '0;
         end
      end else if (cmd.tick) begin
         for (int i = 0; i < NumCables; i++) begin
            travel_ff[i] <= travel_ff[i] - {{(LenW-DirW){dir_in[i][DirW-1]}}, dir_in[i]};
            len_ff[i]    <= len_ff[i] + {{(LenW-DirW){dir_in[i][DirW-1]}}, dir_in[i]};
         end
      end else if (cmd.store) begin
         travel_ff[idx_ff] <= LenW'(root) - len_ff[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= RspDataW'({any_travel, accepted_ff,
                                   dir_ff[3], dir_ff[2], dir_ff[1], dir_ff[0]});
      end
   end

   always_comb begin
      status.mode_tick  = (mode_ff == ModeTick);
      status.any_travel = any_travel;
      status.root_done  = root_done;
      status.last_cable = (idx_ff == IdxW'(NumCables - 1));
      status.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- hdl/crls_ctrl.sv -----
// Controller state machine: sequences capture, tick, the four cable roots and the result.
// Depends on crls_pkg for the command and status structs.
`default_nettype none

module crls_ctrl
   import crls_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire crls_status_type status,
   output crls_cmd_type         cmd
);

   typedef enum logic [3:0] {
      IDLE,
      DECIDE,
      TICK,
      ABS,
      MUL,
      ROOT_START,
      ROOT_WAIT,
      STORE,
      EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = DECIDE;
            end
         end
         DECIDE: begin
            if (status.mode_tick) begin
               state_in = TICK;
            end else if (status.any_travel) begin
               state_in = EMIT;
            end else begin
               cmd.set_accept = 1'b1;
               state_in       = ABS;
            end
         end
         TICK: begin
            cmd.tick = 1'b1;
            state_in = EMIT;
         end
         ABS: begin
            cmd.abs_en = 1'b1;
            state_in   = MUL;
         end
         MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ROOT_START;
         end
         ROOT_START: begin
            cmd.root_start = 1'b1;
            state_in       = ROOT_WAIT;
         end
         ROOT_WAIT: begin
            if (status.root_done) begin
               state_in = STORE;
            end
         end
         STORE: begin
            cmd.store = 1'b1;
            state_in  = status.last_cable ? EMIT : ABS;
         end
         EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/cable_robot_length_stepper_unit.sv -----
// Sequence: a tick word steps the cables; an accepted load word computes the four cables in
// turn (distance, square, 9-step shared root unit, store); a load while moving is refused.
// Handshake: one word at a time; the next word is taken once the result is in the
// output register.
// Reset: synchronous; cable lengths return to 30, travel to zero, board size to 20.
`default_nettype none

module cable_robot_length_stepper_unit
   import crls_pkg::*;
#(
   parameter int COORD_WIDTH = DefCoordW
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [ReqDataW-1:0]  req_tdata,   // target_x[7:0], target_y[15:8]
   input  wire logic                 req_tuser,   // mode[0]
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CoordW-1:0]    csr_data,    // board_size
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RspDataW-1:0]       rsp_tdata    // dir_a[1:0], dir_b[3:2], dir_c[5:4],
                                                  // dir_d[7:6], load_accepted[8], moving[9]
);

   crls_cmd_type    cmd;
   crls_status_type status;

   assign csr_ready = 1'b1;

   crls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   crls_dp #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ----- hdl/crls_checker.sv -----
// Port-level checks for the cable robot length stepper, bound to the top level.
// Depends on crls_pkg.
`default_nettype none

module crls_checker
   import crls_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_tvalid,
   input wire logic                req_tready,
   input wire logic                req_tuser,
   input wire logic                rsp_tvalid,
   input wire logic                rsp_tready,
   input wire logic [RspDataW-1:0] rsp_tdata
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'b10 && rsp_tdata[3:2] != 2'b10 &&
                     rsp_tdata[5:4] != 2'b10 && rsp_tdata[7:6] != 2'b10)
      else $error("illegal step direction");

   a_load_no_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[7:0] == 8'h00)
      else $error("accepted load reports a step");

   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == ModeLoad) |=> !req_tready)
      else $error("ready right after a load word");

endmodule

bind cable_robot_length_stepper_unit crls_checker u_crls_checker (.*);

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for cable_robot_length_stepper_unit: queued load and tick words
// are driven with random gaps, and each response word is checked against a cable model.
// Depends on crls_pkg and the top level of the block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import crls_pkg::*;

   localparam int Plan       = 0;
   localparam int Live       = 1;
   localparam int MaxLength  = 511;
   localparam int CycleLimit = 2_000_000;
   localparam int TailCycles = 100;

   typedef struct packed {
      logic              mode;
      logic [CoordW-1:0] y;
      logic [CoordW-1:0] x;
   } move_word_t;

   typedef struct packed {
      logic [RspDataW-NumCables*DirW-3:0] pad;
      logic                               moving;
      logic                               load_ok;
      logic [NumCables-1:0][DirW-1:0]     dir;
   } step_report_t;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;
   logic                req_tuser  = 1'b0;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [CoordW-1:0]   csr_data   = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;

   logic [CoordW-1:0] board_size = ResetBoard;
   int                cab_len [2][NumCables];
   int                travel  [2][NumCables];
   logic [CoordW-1:0] last_x = '0;
   logic [CoordW-1:0] last_y = '0;

   move_word_t   req_backlog[$];
   step_report_t step_reports_due[$];
   move_word_t   word_on_bus;
   int           words_planned  = 0;
   int           mismatch_count = 0;
   int           cycle_count    = 0;
   int           send_idle = 0, send_calm = 0;
   int           recv_idle = 0, recv_calm = 0;

   cable_robot_length_stepper_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int root_floor(int unsigned v);
      int r;
      r = 0;
      for (int b = 9; b >= 0; b--) begin
         if ((r | (1 << b)) * (r | (1 << b)) <= v)
            r = r | (1 << b);
      end
      return r;
   endfunction

   function automatic int span(int dx, int dy);
      int r;
      r = root_floor(dx * dx + dy * dy);
      return (r > MaxLength) ? MaxLength : r;
   endfunction

   function automatic bit cables_busy(int w);
      for (int i = 0; i < NumCables; i++) begin
         if (travel[w][i] != 0)
            return 1'b1;
      end
      return 1'b0;
   endfunction

   // anchors: cable 0 (0,0), 1 (0,B), 2 (B,B), 3 (B,0)
   function automatic step_report_t advance_cables(int w, move_word_t m);
      step_report_t rep;
      int           ax, ay, b;
      rep = '0;
      b = int'(board_size);
      if (m.mode == ModeLoad) begin
         if (!cables_busy(w)) begin
            for (int i = 0; i < NumCables; i++) begin
               ax = (i >= 2) ? b : 0;
               ay = (i == 1 || i == 2) ? b : 0;
               travel[w][i] = span(int'(m.x) - ax, int'(m.y) - ay) - cab_len[w][i];
            end
            rep.load_ok = 1'b1;
         end
      end else begin
         for (int i = 0; i < NumCables; i++) begin
            if (travel[w][i] > 0) begin
               rep.dir[i] = DirPull;
               travel[w][i]--;
               cab_len[w][i]++;
            end else if (travel[w][i] < 0) begin
               rep.dir[i] = DirPay;
               travel[w][i]++;
               cab_len[w][i]--;
            end
         end
      end
      rep.moving = cables_busy(w);
      return rep;
   endfunction

   task automatic draw_idle(inout int calm, output int gap);
      int r;
      r = $urandom_range(0, 99);
      if (calm > 0) begin
         calm--;
         gap = 0;
      end else if (r < 3) begin
         calm = $urandom_range(10, 50);
         gap = 0;
      end else if (r < 45) begin
         gap = 0;
      end else if (r < 85) begin
         gap = $urandom_range(1, 3);
      end else if (r < 97) begin
         gap = $urandom_range(4, 12);
      end else begin
         gap = $urandom_range(20, 60);
      end
   endtask

   task automatic queue_word(move_word_t m, output step_report_t rep);
      req_backlog.push_back(m);
      words_planned++;
      rep = advance_cables(Plan, m);
   endtask

   task automatic queue_load(logic [CoordW-1:0] x, logic [CoordW-1:0] y);
      step_report_t rep;
      queue_word({ModeLoad, y, x}, rep);
      if (rep.load_ok) begin
         last_x = x;
         last_y = y;
      end
   endtask

   task automatic queue_tick();
      logic [CoordW-1:0] x, y;
      step_report_t      rep;
      x = CoordW'($urandom);
      y = CoordW'($urandom);
      queue_word({ModeTick, y, x}, rep);
   endtask

   // ticks until the planned cables rest or cap is hit; noisy adds stray loads
   task automatic settle(int cap, bit noisy);
      int n;
      n = 0;
      while (cables_busy(Plan) && n < cap) begin
         if (noisy && $urandom_range(0, 24) == 0)
            queue_load(CoordW'($urandom), CoordW'($urandom));
         queue_tick();
         n++;
      end
   endtask

   task automatic pick_target(output logic [CoordW-1:0] x, output logic [CoordW-1:0] y);
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) begin
         x = CoordW'(int'(last_x) + int'($urandom_range(0, 16)) - 8);
         y = CoordW'(int'(last_y) + int'($urandom_range(0, 16)) - 8);
      end else if (k < 90) begin
         x = CoordW'($urandom);
         y = CoordW'($urandom);
      end else begin
         x = $urandom_range(0, 1) ? '1 : '0;
         y = $urandom_range(0, 1) ? '1 : '0;
      end
   endtask

   // settling is cut at the phase budget, so a phase may end with cables moving
   task automatic random_phase(int n);
      int                goal, r, cap;
      logic [CoordW-1:0] x, y;
      goal = words_planned + n;
      while (words_planned < goal) begin
         r = $urandom_range(0, 99);
         if (r < 80) begin
            pick_target(x, y);
            queue_load(x, y);
            cap = ($urandom_range(0, 11) == 0) ? int'($urandom_range(0, 20)) : 1000;
            settle((cap < goal - words_planned) ? cap : goal - words_planned, 1'b1);
         end else if (r < 90) begin
            queue_tick();
         end else begin
            queue_load(CoordW'($urandom), CoordW'($urandom));
         end
      end
   endtask

   task automatic wait_drain();
      while (req_backlog.size() != 0 || req_tvalid || step_reports_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_board(logic [CoordW-1:0] v);
      @(posedge clock);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      board_size = v;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            step_reports_due.push_back(advance_cables(Live, word_on_bus));
         if (!req_tvalid || req_tready) begin
            if (send_idle > 0) begin
               send_idle--;
               req_tvalid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               word_on_bus = req_backlog.pop_front();
               req_tdata  <= {word_on_bus.y, word_on_bus.x};
               req_tuser  <= word_on_bus.mode;
               req_tvalid <= 1'b1;
               draw_idle(send_calm, send_idle);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      step_report_t want, got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (step_reports_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response word %h with none outstanding", $realtime, got);
            end else begin
               want = step_reports_due.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: want dir=%b acc=%b mov=%b pad=%h, ",
                               "got dir=%b acc=%b mov=%b pad=%h"},
                              $realtime, want.dir, want.load_ok, want.moving, want.pad,
                              got.dir, got.load_ok, got.moving, got.pad);
               end
            end
         end
         if (recv_idle > 0) begin
            recv_idle--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            draw_idle(recv_calm, recv_idle);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [CoordW-1:0] boards [8];
      for (int w = 0; w < 2; w++) begin
         for (int i = 0; i < NumCables; i++) begin
            cab_len[w][i] = int'(ResetLength);
            travel[w][i]  = 0;
         end
      end
      boards = '{8'd255, 8'd1, 8'd0, 8'd0, 8'd128, 8'd0, 8'd0, ResetBoard};
      boards[3] = CoordW'($urandom_range(1, 254));
      boards[5] = CoordW'($urandom_range(1, 254));
      boards[6] = CoordW'($urandom_range(1, 254));
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset board: tick at rest, load, stray loads while moving, run out
      queue_tick();
      queue_load(8'd10, 8'd10);
      queue_tick();
      queue_load('1, '1);
      queue_load('0, '0);
      settle(1000, 1'b0);
      wait_drain();

      // zero board: all anchors at the origin, load with no travel
      write_board('0);
      queue_load(8'd10, 8'd10);
      queue_tick();
      queue_load(8'd11, 8'd11);
      queue_tick();
      wait_drain();

      foreach (boards[p]) begin
         write_board(boards[p]);
         random_phase(190);
         wait_drain();
      end

      repeat (TailCycles) @(posedge clock);
      if (mismatch_count == 0 && step_reports_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
